FILE: design/tli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tli_pkg;

    localparam int TAPE_CELLS    = 32768;
    localparam int PROGRAM_DEPTH = 4096;

    localparam int TA_W   = $clog2(TAPE_CELLS);
    localparam int PA_W   = $clog2(PROGRAM_DEPTH);
    localparam int PC_W   = $clog2(PROGRAM_DEPTH + 1);
    localparam int ACT_W  = 2;
    localparam int BYTE_W = 8;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 13;
    localparam int RUN_W  = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;

    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;

    localparam logic [RUN_W-1:0] RUN_OK        = 2'd0;
    localparam logic [RUN_W-1:0] RUN_BAD_OPEN  = 2'd1;
    localparam logic [RUN_W-1:0] RUN_BAD_CLOSE = 2'd2;

    localparam logic [ST_W-1:0] ST_EXEC  = 3'd0;
    localparam logic [ST_W-1:0] ST_WAIT  = 3'd1;
    localparam logic [ST_W-1:0] ST_END   = 3'd2;
    localparam logic [ST_W-1:0] ST_OPEN  = 3'd3;
    localparam logic [ST_W-1:0] ST_CLOSE = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd5;
    localparam logic [ST_W-1:0] ST_DONE  = 3'd6;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic clr;
    } tli_cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_clear;
        logic scan_req;
        logic scan_done;
        logic clr_last;
    } tli_stat_t;

endpackage
`default_nettype wire

FILE: design/tli_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tli_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  tli_pkg::tli_stat_t  stat,
    output tli_pkg::tli_cmd_t   cmd
);
    import tli_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_CLR  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        item_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec = 1'b1;
                    if (stat.is_clear)
                        state_next = S_CLR;
                    else if (stat.scan_req)
                        state_next = S_SCAN;
                    else
                        state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!stat.scan_done || stat.out_free)
                begin
                    cmd.scan = 1'b1;
                    if (stat.scan_done)
                        state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

FILE: design/tli_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tli_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tli_pkg::tli_cmd_t             cmd,
    output tli_pkg::tli_stat_t            stat,
    input  logic [tli_pkg::ACT_W-1:0]     action,
    input  logic [tli_pkg::BYTE_W-1:0]    program_byte,
    input  logic [tli_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          in_valid,
    input  logic                          in_eof,
    input  logic                          result_stall,
    output logic                          result_valid,
    output logic                          out_valid,
    output logic [tli_pkg::BYTE_W-1:0]    out_byte,
    output logic [tli_pkg::ST_W-1:0]      status,
    output logic [tli_pkg::CNT_W-1:0]     counter_now
);
    import tli_pkg::*;

    logic [BYTE_W-1:0] prog_mem [PROGRAM_DEPTH];
    logic [BYTE_W-1:0] tape_mem [TAPE_CELLS];
    logic [BYTE_W-1:0] prog_rd_reg;
    logic [BYTE_W-1:0] tape_rd_reg;

    logic [ACT_W-1:0]  act_reg;
    logic [BYTE_W-1:0] pbyte_reg;
    logic [BYTE_W-1:0] ibyte_reg;
    logic              ivalid_reg;
    logic              ieof_reg;

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [PC_W-1:0]   len_reg, len_next;
    logic [TA_W-1:0]   cp_reg, cp_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [TA_W-1:0]   clr_reg, clr_next;
    logic              pend_reg, pend_next;
    logic              dir_reg, dir_next;
    logic [PC_W-1:0]   rdj_reg, rdj_next;
    logic [PC_W-1:0]   chk_reg, chk_next;
    logic [PC_W-1:0]   dep_reg, dep_next;

    logic              resv_reg, resv_next;
    logic              res_ov_reg, res_ov_next;
    logic [BYTE_W-1:0] res_ob_reg, res_ob_next;
    logic [ST_W-1:0]   res_st_reg, res_st_next;
    logic [CNT_W-1:0]  res_cnt_reg, res_cnt_next;

    logic              prog_re;
    logic [PA_W-1:0]   prog_raddr;
    logic              prog_we;
    logic              tape_we;
    logic [TA_W-1:0]   tape_waddr;
    logic [BYTE_W-1:0] tape_wdata;
    logic              load;
    logic              ov;
    logic [BYTE_W-1:0] ob;
    logic [ST_W-1:0]   st;

    logic              is_step;
    logic              runnable;
    logic              scan_start;
    logic              sc_inc;
    logic              sc_dec;
    logic [PC_W-1:0]   dep_after;
    logic [PC_W-1:0]   scan_addr;
    logic              matched;
    logic              fail;

    assign is_step    = (act_reg != ACT_CLEAR) && (act_reg != ACT_LOAD);
    assign runnable   = is_step && (run_reg == RUN_OK) && (pc_reg < len_reg);
    assign scan_start = runnable &&
                        (((prog_rd_reg == CH_OPEN) && (tape_rd_reg == '0)) ||
                         ((prog_rd_reg == CH_CLOSE) && (tape_rd_reg != '0)));

    // bracket walk: depth counts the opening kind up, the matching kind down
    assign sc_inc    = dir_reg ? (prog_rd_reg == CH_CLOSE) : (prog_rd_reg == CH_OPEN);
    assign sc_dec    = dir_reg ? (prog_rd_reg == CH_OPEN) : (prog_rd_reg == CH_CLOSE);
    assign dep_after = dep_reg + PC_W'(sc_inc) - PC_W'(sc_dec);
    assign scan_addr = dir_reg ? (rdj_reg - 1'b1) : rdj_reg;
    assign matched   = pend_reg && (dep_after == '0);
    assign fail      = !matched && (dir_reg ? (rdj_reg == '0) : (rdj_reg >= len_reg));

    always_comb
    begin
        stat.out_free  = !resv_reg || !result_stall;
        stat.is_clear  = (act_reg == ACT_CLEAR);
        stat.scan_req  = scan_start;
        stat.scan_done = matched || fail;
        stat.clr_last  = (clr_reg == TA_W'(TAPE_CELLS - 1));
    end

    always_comb
    begin
        pc_next      = pc_reg;
        len_next     = len_reg;
        cp_next      = cp_reg;
        run_next     = run_reg;
        clr_next     = clr_reg;
        pend_next    = pend_reg;
        dir_next     = dir_reg;
        rdj_next     = rdj_reg;
        chk_next     = chk_reg;
        dep_next     = dep_reg;
        resv_next    = (resv_reg && !result_stall) ? 1'b0 : resv_reg;
        res_ov_next  = res_ov_reg;
        res_ob_next  = res_ob_reg;
        res_st_next  = res_st_reg;
        res_cnt_next = res_cnt_reg;
        prog_re      = cmd.capture;
        prog_raddr   = pc_reg[PA_W-1:0];
        prog_we      = 1'b0;
        tape_we      = 1'b0;
        tape_waddr   = cp_reg;
        tape_wdata   = '0;
        load         = 1'b0;
        ov           = 1'b0;
        ob           = '0;
        st           = ST_EXEC;

        if (cmd.exec)
        begin
            load = 1'b1;
            unique case (act_reg)
                ACT_CLEAR:
                begin
                    pc_next  = '0;
                    len_next = '0;
                    cp_next  = '0;
                    run_next = RUN_OK;
                    clr_next = '0;
                    st       = ST_DONE;
                end
                ACT_LOAD:
                begin
                    if (len_reg < PC_W'(PROGRAM_DEPTH))
                    begin
                        prog_we  = 1'b1;
                        len_next = len_reg + 1'b1;
                        st       = ST_DONE;
                    end
                    else
                        st = ST_FULL;
                end
                default:
                begin
                    if (run_reg == RUN_BAD_OPEN)
                        st = ST_OPEN;
                    else if (run_reg == RUN_BAD_CLOSE)
                        st = ST_CLOSE;
                    else if (!runnable)
                        st = ST_END;
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                        unique case (prog_rd_reg) inside
                            CH_RIGHT:
                                cp_next = (cp_reg == TA_W'(TAPE_CELLS - 1)) ? '0
                                                                            : cp_reg + 1'b1;
                            CH_LEFT:
                                cp_next = (cp_reg == '0) ? TA_W'(TAPE_CELLS - 1)
                                                         : cp_reg - 1'b1;
                            CH_INC:
                            begin
                                tape_we    = 1'b1;
                                tape_wdata = tape_rd_reg + 1'b1;
                            end
                            CH_DEC:
                            begin
                                tape_we    = 1'b1;
                                tape_wdata = tape_rd_reg - 1'b1;
                            end
                            CH_OUT:
                            begin
                                ov = 1'b1;
                                ob = tape_rd_reg;
                            end
                            CH_IN:
                            begin
                                if (!ivalid_reg)
                                begin
                                    pc_next = pc_reg;
                                    st      = ST_WAIT;
                                end
                                else
                                begin
                                    tape_we    = 1'b1;
                                    tape_wdata = (ieof_reg || (ibyte_reg == CH_NL)) ? '0
                                                                                    : ibyte_reg;
                                end
                            end
                            CH_OPEN, CH_CLOSE:
                            begin
                                if (scan_start)
                                begin
                                    load      = 1'b0;
                                    pc_next   = pc_reg;
                                    dir_next  = (prog_rd_reg == CH_CLOSE);
                                    rdj_next  = (prog_rd_reg == CH_CLOSE) ? pc_reg
                                                                          : pc_reg + 1'b1;
                                    pend_next = 1'b0;
                                    dep_next  = PC_W'(1);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            endcase
        end

        if (cmd.scan)
        begin
            if (matched)
            begin
                pc_next = chk_reg + 1'b1;
                st      = ST_EXEC;
                load    = 1'b1;
            end
            else if (fail)
            begin
                run_next = dir_reg ? RUN_BAD_CLOSE : RUN_BAD_OPEN;
                st       = dir_reg ? ST_CLOSE : ST_OPEN;
                load     = 1'b1;
            end
            else
            begin
                prog_re    = 1'b1;
                prog_raddr = scan_addr[PA_W-1:0];
                chk_next   = scan_addr;
                rdj_next   = dir_reg ? (rdj_reg - 1'b1) : (rdj_reg + 1'b1);
                pend_next  = 1'b1;
                if (pend_reg)
                    dep_next = dep_after;
            end
        end

        if (cmd.clr)
        begin
            tape_we    = 1'b1;
            tape_waddr = clr_reg;
            tape_wdata = '0;
            clr_next   = clr_reg + 1'b1;
        end

        if (load)
        begin
            resv_next    = 1'b1;
            res_ov_next  = ov;
            res_ob_next  = ob;
            res_st_next  = st;
            res_cnt_next = CNT_W'(pc_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (prog_we)
            prog_mem[len_reg[PA_W-1:0]] <= pbyte_reg;
        if (prog_re)
            prog_rd_reg <= prog_mem[prog_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tape_we)
            tape_mem[tape_waddr] <= tape_wdata;
        if (cmd.capture)
            tape_rd_reg <= tape_mem[cp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg    <= action;
            pbyte_reg  <= program_byte;
            ibyte_reg  <= in_byte;
            ivalid_reg <= in_valid;
            ieof_reg   <= in_eof;
        end
        dir_reg     <= dir_next;
        rdj_reg     <= rdj_next;
        chk_reg     <= chk_next;
        dep_reg     <= dep_next;
        res_ov_reg  <= res_ov_next;
        res_ob_reg  <= res_ob_next;
        res_st_reg  <= res_st_next;
        res_cnt_reg <= res_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            len_reg  <= '0;
            cp_reg   <= '0;
            run_reg  <= RUN_OK;
            clr_reg  <= '0;
            pend_reg <= 1'b0;
            resv_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            len_reg  <= len_next;
            cp_reg   <= cp_next;
            run_reg  <= run_next;
            clr_reg  <= clr_next;
            pend_reg <= pend_next;
            resv_reg <= resv_next;
        end
    end

    assign result_valid = resv_reg;
    assign out_valid    = res_ov_reg;
    assign out_byte     = res_ob_reg;
    assign status       = res_st_reg;
    assign counter_now  = res_cnt_reg;

endmodule
`default_nettype wire

FILE: design/tape_language_interpreter.sv
// Tape language interpreter.
// Input channel item_valid/item_stall carries action, program_byte, in_byte,
// in_valid and in_eof; a transfer takes place when item_valid is high and
// item_stall low. Action 0 clears and restarts, 1 appends a program byte,
// 2 or 3 executes one command.
// Result channel result_valid/result_stall carries out_valid, out_byte, status
// and counter_now; exactly one result per input transfer, in order.
// For a plain command, load or step, the transfer cycle reads the program and
// tape memories into registers; execution then works from the registered data.
// A bracket jump walks the program byte by byte to find its match.
// After reset and after each clear the tape is zeroed one cell per cycle
// with item_stall high; the clear result is already available.
// The result register lets the next item transfer in while a result waits;
// if result_stall holds the register full, execution waits before writing
// its result and item_stall stays high.
`timescale 1ns / 1ps
`default_nettype none
module tape_language_interpreter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [tli_pkg::ACT_W-1:0]     action,
    input  logic [tli_pkg::BYTE_W-1:0]    program_byte,
    input  logic [tli_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          in_valid,
    input  logic                          in_eof,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          out_valid,
    output logic [tli_pkg::BYTE_W-1:0]    out_byte,
    output logic [tli_pkg::ST_W-1:0]      status,
    output logic [tli_pkg::CNT_W-1:0]     counter_now
);
    import tli_pkg::*;

    tli_cmd_t  cmd;
    tli_stat_t stat;

    tli_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    tli_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .program_byte (program_byte),
        .in_byte      (in_byte),
        .in_valid     (in_valid),
        .in_eof       (in_eof),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .status       (status),
        .counter_now  (counter_now)
    );

endmodule
`default_nettype wire

FILE: tb/tape_language_interpreter_checker.sv
`timescale 1ns / 1ps
module tape_language_interpreter_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  logic [tli_pkg::ACT_W-1:0]     action,
    input  logic [tli_pkg::BYTE_W-1:0]    program_byte,
    input  logic [tli_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          in_valid,
    input  logic                          in_eof,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic                          out_valid,
    input  logic [tli_pkg::BYTE_W-1:0]    out_byte,
    input  logic [tli_pkg::ST_W-1:0]      status,
    input  logic [tli_pkg::CNT_W-1:0]     counter_now,
    output int                            errors,
    output int                            pending
);
    import tli_pkg::*;

    typedef struct packed {
        logic              ov;
        logic [BYTE_W-1:0] ob;
        logic [ST_W-1:0]   st;
        logic [CNT_W-1:0]  cnt;
    } step_result_t;

    logic [BYTE_W-1:0] prog_mem [PROGRAM_DEPTH];
    logic [BYTE_W-1:0] tape_mem [TAPE_CELLS];
    int                prog_len;
    int                pc;
    int                cp;
    logic [RUN_W-1:0]  run_state;
    step_result_t      expected_q [$];
    int                fail_count;

    function automatic void wipe();
        int i;
        for (i = 0; i < PROGRAM_DEPTH; i++)
            prog_mem[i] = '0;
        for (i = 0; i < TAPE_CELLS; i++)
            tape_mem[i] = '0;
        prog_len  = 0;
        pc        = 0;
        cp        = 0;
        run_state = RUN_OK;
    endfunction

    function automatic step_result_t interpret(
        input logic [ACT_W-1:0]  act,
        input logic [BYTE_W-1:0] pb,
        input logic [BYTE_W-1:0] ib,
        input logic              iv,
        input logic              ie
    );
        step_result_t      r;
        logic [BYTE_W-1:0] op;
        logic [BYTE_W-1:0] c;
        int                depth;
        int                j;
        int                npc;
        r = '0;
        if (act == ACT_CLEAR)
        begin
            wipe();
            r.st = ST_DONE;
        end
        else if (act == ACT_LOAD)
        begin
            if (prog_len < PROGRAM_DEPTH)
            begin
                prog_mem[prog_len] = pb;
                prog_len++;
                r.st = ST_DONE;
            end
            else
                r.st = ST_FULL;
        end
        else if (run_state == RUN_BAD_OPEN)
            r.st = ST_OPEN;
        else if (run_state == RUN_BAD_CLOSE)
            r.st = ST_CLOSE;
        else if (pc >= prog_len)
            r.st = ST_END;
        else
        begin
            op   = prog_mem[pc];
            npc  = pc;
            r.st = ST_EXEC;
            case (op)
                CH_RIGHT: cp = (cp + 1) % TAPE_CELLS;
                CH_LEFT:  cp = (cp == 0) ? TAPE_CELLS - 1 : cp - 1;
                CH_INC:   tape_mem[cp] = tape_mem[cp] + 8'd1;
                CH_DEC:   tape_mem[cp] = tape_mem[cp] - 8'd1;
                CH_OUT:
                begin
                    r.ov = 1'b1;
                    r.ob = tape_mem[cp];
                end
                CH_IN:
                begin
                    if (!iv)
                        r.st = ST_WAIT;
                    else if (ie || ib == CH_NL)
                        tape_mem[cp] = '0;
                    else
                        tape_mem[cp] = ib;
                end
                CH_OPEN:
                begin
                    if (tape_mem[cp] == '0)
                    begin
                        depth = 1;
                        j = pc + 1;
                        while (j < prog_len && depth != 0)
                        begin
                            c = prog_mem[j];
                            if (c == CH_OPEN)
                                depth++;
                            else if (c == CH_CLOSE)
                                depth--;
                            if (depth != 0)
                                j++;
                        end
                        if (depth != 0)
                        begin
                            run_state = RUN_BAD_OPEN;
                            r.st = ST_OPEN;
                        end
                        else
                            npc = j;
                    end
                end
                CH_CLOSE:
                begin
                    if (tape_mem[cp] != '0)
                    begin
                        depth = 1;
                        j = pc;
                        while (j > 0 && depth != 0)
                        begin
                            j--;
                            c = prog_mem[j];
                            if (c == CH_CLOSE)
                                depth++;
                            else if (c == CH_OPEN)
                                depth--;
                        end
                        if (depth != 0)
                        begin
                            run_state = RUN_BAD_CLOSE;
                            r.st = ST_CLOSE;
                        end
                        else
                            npc = j;
                    end
                end
                default: ;
            endcase
            if (r.st == ST_EXEC)
                pc = npc + 1;
        end
        r.cnt = CNT_W'(pc);
        return r;
    endfunction

    function automatic int differs(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        step_result_t want;
        int           bad;
        if (!rst_n)
        begin
            wipe();
            expected_q.delete();
            fail_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_q.push_back(interpret(action, program_byte, in_byte,
                                               in_valid, in_eof));
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad = differs("out_valid", 32'(want.ov), 32'(out_valid))
                        + differs("out_byte", 32'(want.ob), 32'(out_byte))
                        + differs("status", 32'(want.st), 32'(status))
                        + differs("counter_now", 32'(want.cnt), 32'(counter_now));
                    if (bad != 0)
                        fail_count++;
                end
            end
            errors  <= fail_count;
            pending <= expected_q.size();
        end
    end

endmodule

FILE: tb/tape_language_interpreter_tb.sv
`timescale 1ns / 1ps
module tape_language_interpreter_tb;
    import tli_pkg::*;

    localparam logic [ACT_W-1:0] ACT_STEP     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_STEP_ALT = 2'd3;
    localparam int WATCHDOG_LIMIT = 150000;
    localparam int RANDOM_ITEMS   = 1580;
    localparam int JUMP_LEN       = 200;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    logic [ACT_W-1:0]  action       = ACT_CLEAR;
    logic [BYTE_W-1:0] program_byte = '0;
    logic [BYTE_W-1:0] in_byte      = '0;
    logic              in_valid     = 1'b0;
    logic              in_eof       = 1'b0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  counter_now;

    int errors;
    int pending;
    int quiet_cycles = 0;
    int n_loads      = 0;
    int n_steps      = 0;
    int n_clears     = 0;
    bit calm         = 1'b0;

    tape_language_interpreter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .program_byte (program_byte),
        .in_byte      (in_byte),
        .in_valid     (in_valid),
        .in_eof       (in_eof),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .status       (status),
        .counter_now  (counter_now)
    );

    tape_language_interpreter_checker tape_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .program_byte (program_byte),
        .in_byte      (in_byte),
        .in_valid     (in_valid),
        .in_eof       (in_eof),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .status       (status),
        .counter_now  (counter_now),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        result_stall <= !calm && ($urandom_range(0, 99) < 35);

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tape_language_interpreter test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic put_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] pb,
                            input logic [BYTE_W-1:0] ib, input logic iv, input logic ie);
        if (!calm && $urandom_range(0, 99) < 35)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        item_valid   = 1'b1;
        action       = act;
        program_byte = pb;
        in_byte      = ib;
        in_valid     = iv;
        in_eof       = ie;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        if (act == ACT_CLEAR)
            n_clears++;
        else if (act == ACT_LOAD)
            n_loads++;
        else
            n_steps++;
    endtask

    task automatic rest();
        item_valid = 1'b0;
    endtask

    task automatic load_byte(input logic [BYTE_W-1:0] b);
        put_item(ACT_LOAD, b, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    endtask

    task automatic clear_item();
        put_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic step_with(input logic [ACT_W-1:0] act, input logic iv,
                             input logic [BYTE_W-1:0] ib, input logic ie);
        put_item(act, 8'($urandom_range(0, 255)), ib, iv, ie);
    endtask

    task automatic step_any();
        logic [BYTE_W-1:0] ib;
        case ($urandom_range(0, 9))
            0:       ib = CH_NL;
            1:       ib = 8'hFF;
            2:       ib = 8'h00;
            default: ib = 8'($urandom_range(0, 255));
        endcase
        step_with(($urandom_range(0, 99) < 85) ? ACT_STEP : ACT_STEP_ALT,
                  $urandom_range(0, 99) < 85, ib, $urandom_range(0, 99) < 10);
    endtask

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        case ($urandom_range(0, 15))
            0, 1, 2: b = CH_INC;
            3, 4:    b = CH_DEC;
            5, 6:    b = CH_RIGHT;
            7, 8:    b = CH_LEFT;
            9, 10:   b = CH_OUT;
            11, 12:  b = CH_IN;
            default:
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_OPEN || b == CH_CLOSE)
                    b = 8'h00;
            end
        endcase
        return b;
    endfunction

    // balanced loops; a broken snippet ends with a stray bracket
    task automatic append_snippet(input int len, input bit broken);
        int i;
        int opened;
        int left;
        logic [BYTE_W-1:0] b;
        opened = 0;
        for (i = 0; i < len; i++)
        begin
            left = len - i;
            if (opened > 0 && (left <= opened || $urandom_range(0, 99) < 15))
            begin
                b = CH_CLOSE;
                opened--;
            end
            else if (left > opened + 2 && $urandom_range(0, 99) < 15)
            begin
                b = CH_OPEN;
                opened++;
            end
            else
                b = plain_byte();
            load_byte(b);
        end
        if (broken)
            load_byte($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
    endtask

    initial
    begin : stimulus
        int  i;
        int  seg;
        int  len;
        bit  broken;
        bit  was_broken;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty program, both step codes
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);
        step_with(ACT_STEP_ALT, 1'b0, 8'hFF, 1'b1);
        // pointer wrap below cell zero, decrement through zero, output
        load_byte(CH_LEFT);
        step_with(ACT_STEP, 1'b0, 8'h00, 1'b0);
        load_byte(CH_DEC);
        step_with(ACT_STEP, 1'b0, 8'h00, 1'b0);
        load_byte(CH_OUT);
        step_with(ACT_STEP, 1'b0, 8'h00, 1'b0);
        // read: no input, newline, byte 255, end of input
        load_byte(CH_IN);
        step_with(ACT_STEP, 1'b0, 8'h55, 1'b1);
        step_with(ACT_STEP, 1'b1, CH_NL, 1'b0);
        load_byte(CH_IN);
        step_with(ACT_STEP, 1'b1, 8'hFF, 1'b0);
        load_byte(CH_IN);
        step_with(ACT_STEP_ALT, 1'b1, 8'h41, 1'b1);
        // unknown bytes are no-ops
        load_byte(8'h00);
        load_byte(8'hFF);
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);
        load_byte(CH_RIGHT);
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);
        // unmatched open stays stuck, loads still taken
        load_byte(CH_OPEN);
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);
        load_byte(CH_INC);
        clear_item();
        // unmatched close
        load_byte(CH_INC);
        load_byte(CH_CLOSE);
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);
        clear_item();

        seg = 0;
        was_broken = 1'b0;
        while (n_loads + n_steps + n_clears < RANDOM_ITEMS)
        begin
            if (seg == 12)
            begin
                rest();
                while (pending != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            calm = (seg >= 20 && seg < 28);
            if (n_clears < 12 && (was_broken || $urandom_range(0, 99) < 5))
                clear_item();
            len = $urandom_range(3, 20);
            broken = ($urandom_range(0, 99) < 4);
            append_snippet(len, broken);
            was_broken = broken;
            repeat (len + $urandom_range(0, len))
                step_any();
            seg++;
        end

        // one long forward jump over the whole program
        calm = 1'b0;
        clear_item();
        for (i = 0; i < JUMP_LEN; i++)
        begin
            if (i == 0)
                load_byte(CH_OPEN);
            else if (i == JUMP_LEN - 1)
                load_byte(CH_CLOSE);
            else
                load_byte(plain_byte());
        end
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);
        step_with(ACT_STEP, 1'b1, 8'h00, 1'b0);

        rest();
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("%0d transfers: %0d program loads, %0d steps, %0d clears.",
                 n_loads + n_steps + n_clears, n_loads, n_steps, n_clears);
        $display("Covered pointer wrap, reads and end of input, loops, bad brackets, long jump.");
        if (errors == 0)
            $display("tape_language_interpreter test passed");
        else
            $display("tape_language_interpreter test failed");
        $finish;
    end

endmodule

FILE: files.f
design/tli_pkg.sv
design/tli_ctrl.sv
design/tli_datapath.sv
design/tape_language_interpreter.sv
tb/tape_language_interpreter_checker.sv
tb/tape_language_interpreter_tb.sv
